>>> src/wddi_pkg.sv
// Shared types and constants for the windowed drift depth index block.
// Field widths, register reset values, fixed-point scale constants,
// sequencer states and the history command struct. No dependencies.
package wddi_pkg;

    // Field widths
    localparam int MASS_W  = 24;
    localparam int ACT_W   = 2;
    localparam int DS_W    = 13;
    localparam int DL_W    = 15;
    localparam int ICS_W   = 16;
    localparam int MCS_W   = 4;
    localparam int MCL_W   = 6;

    // Default window lengths in half-hour entries
    localparam int SHORT_WINDOW_DEF = 12;
    localparam int LONG_WINDOW_DEF  = 48;

    // Depth scale: sum * DEPTH_NUM * inv_cos / (539 * 2^14), round half up
    localparam int DEPTH_NUM     = 18000;
    localparam int DEN_ODD       = 539;
    localparam int DEN_ODD_W     = $clog2(DEN_ODD);
    localparam int DEN_SHIFT     = 14;
    localparam int DEPTH_DEN     = DEN_ODD << DEN_SHIFT;
    localparam int DEPTH_HALF    = DEPTH_DEN / 2;
    localparam int CAP_PER_ENTRY = 640;

    // Shared multiplier: second operand width and low split of the product
    localparam int MUL_B_W = 16;
    localparam int SPLIT_W = 24;

    // Configuration port
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int ICS_RESET = 16384;
    localparam int MCS_RESET = 9;
    localparam int MCL_RESET = 36;

    typedef enum logic [ACT_W-1:0] {
        ACT_RECOMPUTE = 2'd0,
        ACT_OVERWRITE = 2'd1,
        ACT_SHIFT     = 2'd2
    } act_t;

    typedef enum logic [1:0] {
        REG_INV_COS   = 2'd0,
        REG_MIN_SHORT = 2'd1,
        REG_MIN_LONG  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_EVAL,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_CHECK,
        ST_RCP,
        ST_DONE
    } state_t;

    // Command from the sequencer to the history store
    typedef struct packed {
        logic              wr_en;
        logic              shift;
        logic              wr_def;
        logic [MASS_W-1:0] wr_mass;
        logic              rd_en;
    } hist_cmd_t;

endpackage

>>> src/wddi_if.sv
// Valid/ready channel interfaces for the drift depth index block.
// Input item channel and result channel; widths from wddi_pkg.
interface wddi_in_if
    import wddi_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic signed [MASS_W-1:0] new_mass;
    logic                     new_defined;

    modport source (output valid, action, new_mass, new_defined, input ready);
    modport sink   (input valid, action, new_mass, new_defined, output ready);
endinterface

interface wddi_out_if
    import wddi_pkg::*;
    ();
    logic            valid;
    logic            ready;
    logic [DS_W-1:0] depth_short;
    logic            short_valid;
    logic [DL_W-1:0] depth_long;
    logic            long_valid;

    modport source (output valid, depth_short, short_valid, depth_long, long_valid,
                    input ready);
    modport sink   (input valid, depth_short, short_valid, depth_long, long_valid,
                    output ready);
endinterface

>>> src/windowed_drift_depth_index.sv
// Windowed drift depth index, top level: APB register file, sequencer and
// shared multiplier. Depends on wddi_pkg, wddi_if and wddi_hist.
//
// Usage: each transaction on the item channel carries an action (recompute,
// overwrite newest entry, or shift in a new entry), an eroded mass and its
// defined flag. After updating the history the block sums the defined
// entries of the short and the long window and returns one transaction on
// the result channel with both depths and their valid flags.
// Timing: the history is walked one memory read per cycle, then each window
// closes in the evaluate state when invalid or non-positive, in the check
// state when capped, or goes on through the shared multiplier, where the scale
// division is a shift and a two-part reciprocal multiply. item.ready is high
// only while the sequencer is idle, so the block takes no new item before
// the result of the last one has been passed to the output register.
// The result sits in an output register: a stalled receiver does not stop
// the next item being taken, but the sequencer holds in its final state
// until that register is free. Reset marks all history entries undefined,
// loads the register reset values and empties the output register.
// Configuration writes are taken at any time over APB; pready is tied high.
module windowed_drift_depth_index
    import wddi_pkg::*;
#(
    parameter int SHORT_WINDOW = SHORT_WINDOW_DEF,
    parameter int LONG_WINDOW  = LONG_WINDOW_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    wddi_in_if.sink            item,
    wddi_out_if.source         result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int SW_EFF = (SHORT_WINDOW > LONG_WINDOW) ? LONG_WINDOW : SHORT_WINDOW;
    localparam int AW     = $clog2(LONG_WINDOW);
    localparam int CNT_W  = $clog2(LONG_WINDOW + 1);
    localparam int CMP_W  = (CNT_W > MCL_W) ? CNT_W : MCL_W;
    localparam int SUM_W  = MASS_W + CNT_W;
    localparam int MA_W   = SUM_W - 1;
    localparam int PR_W   = MA_W + MUL_B_W;
    localparam int NUM_W  = PR_W + MUL_B_W;
    localparam int CAP_S  = SW_EFF * CAP_PER_ENTRY;
    localparam int CAP_L  = LONG_WINDOW * CAP_PER_ENTRY;
    localparam int QW     = $clog2(CAP_L + 1);
    localparam logic [NUM_W-1:0] THR_S =
        NUM_W'((64'(CAP_S) + 64'd1) * 64'(DEPTH_DEN));
    localparam logic [NUM_W-1:0] THR_L =
        NUM_W'((64'(CAP_L) + 64'd1) * 64'(DEPTH_DEN));
    // Reciprocal of the odd scale factor, exact for dividends below 2^NQ_W
    localparam int NQ_W   = QW + DEN_ODD_W;
    localparam int RCP_SH = NQ_W + DEN_ODD_W;
    localparam logic [63:0] RCP_M =
        ((64'd1 << RCP_SH) + 64'(DEN_ODD - 1)) / 64'(DEN_ODD);
    localparam logic [MUL_B_W-1:0] RCP_LO = RCP_M[MUL_B_W-1:0];
    localparam logic [MUL_B_W-1:0] RCP_HI = MUL_B_W'(RCP_M >> MUL_B_W);

    // Control state
    state_t              state_reg, state_next;
    logic                win_reg, win_next;
    logic                pend_reg, pend_next;
    logic                o_vld_reg, o_vld_next;
    logic [ICS_W-1:0]    ics_reg, ics_next;
    logic [MCS_W-1:0]    mcs_reg, mcs_next;
    logic [MCL_W-1:0]    mcl_reg, mcl_next;

    // Datapath
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [AW-1:0]           pidx_reg, pidx_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next, ssum_reg, ssum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next, scnt_reg, scnt_next;
    logic [PR_W-1:0]         prod_reg, prod_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [NUM_W-1:0]        rem_reg, rem_next;
    logic                    wv_reg, wv_next;
    logic [QW-1:0]           ds_reg, ds_next, dl_reg, dl_next;
    logic                    sv_reg, sv_next, lv_reg, lv_next;
    logic [DS_W-1:0]         o_ds_reg, o_ds_next;
    logic [DL_W-1:0]         o_dl_reg, o_dl_next;
    logic                    o_sv_reg, o_sv_next, o_lv_reg, o_lv_next;

    // Combinational helpers
    hist_cmd_t               hcmd;
    logic [MASS_W-1:0]       rd_mass;
    logic                    rd_def;
    logic                    accept;
    logic                    cfg_wr;
    reg_idx_t                cfg_idx;
    logic signed [SUM_W-1:0] acc_sum;
    logic [CNT_W-1:0]        acc_cnt;
    logic signed [SUM_W-1:0] sel_sum;
    logic [CMP_W-1:0]        sel_cnt, sel_thr;
    logic [NUM_W-1:0]        sel_lim;
    logic [QW-1:0]           sel_cap;
    logic [MA_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [PR_W-1:0]         mul_res;
    logic [NUM_W-1:0]        rcp_acc;
    logic                    fin;
    logic [QW-1:0]           fin_depth;
    logic                    fin_valid;
    logic                    w_valid;
    logic                    w_pos;

    wddi_hist #(
        .LONG_WINDOW (LONG_WINDOW)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (hcmd),
        .rd_idx  (idx_reg[AW-1:0]),
        .rd_mass (rd_mass),
        .rd_def  (rd_def)
    );

    assign accept      = item.valid && item.ready;
    assign item.ready  = (state_reg == ST_IDLE);

    // Configuration port
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign pready  = 1'b1;

    always_comb
    begin
        ics_next = ics_reg;
        mcs_next = mcs_reg;
        mcl_next = mcl_reg;
        prdata   = '0;
        case (cfg_idx)
            REG_INV_COS:
            begin
                prdata = PDATA_W'(ics_reg);
                if (cfg_wr)
                begin
                    ics_next = pwdata[ICS_W-1:0];
                end
            end
            REG_MIN_SHORT:
            begin
                prdata = PDATA_W'(mcs_reg);
                if (cfg_wr)
                begin
                    mcs_next = pwdata[MCS_W-1:0];
                end
            end
            REG_MIN_LONG:
            begin
                prdata = PDATA_W'(mcl_reg);
                if (cfg_wr)
                begin
                    mcl_next = pwdata[MCL_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // Window selection and the shared units
    assign sel_sum = win_reg ? sum_reg : ssum_reg;
    assign sel_cnt = win_reg ? CMP_W'(cnt_reg) : CMP_W'(scnt_reg);
    assign sel_thr = win_reg ? CMP_W'(mcl_reg) : CMP_W'(mcs_reg);
    assign sel_lim = win_reg ? THR_L : THR_S;
    assign sel_cap = win_reg ? QW'(CAP_L) : QW'(CAP_S);
    assign mul_res = PR_W'(mul_a) * PR_W'(mul_b);
    assign w_valid = (sel_cnt > sel_thr);
    assign w_pos   = !sel_sum[SUM_W-1] && (sel_sum != '0);

    // Combine the low reciprocal partial product with the high one
    assign rcp_acc = rem_reg + (NUM_W'(mul_res) << MUL_B_W);

    // Accumulate one history entry
    assign acc_sum = sum_reg + (rd_def ?
        {{(SUM_W-MASS_W){rd_mass[MASS_W-1]}}, rd_mass} : SUM_W'(0));
    assign acc_cnt = cnt_reg + CNT_W'(rd_def);

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        win_next   = win_reg;
        pend_next  = 1'b0;
        o_vld_next = o_vld_reg && !result.ready;
        idx_next   = idx_reg;
        pidx_next  = pidx_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        ssum_next  = ssum_reg;
        scnt_next  = scnt_reg;
        prod_next  = prod_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        wv_next    = wv_reg;
        ds_next    = ds_reg;
        dl_next    = dl_reg;
        sv_next    = sv_reg;
        lv_next    = lv_reg;
        o_ds_next  = o_ds_reg;
        o_dl_next  = o_dl_reg;
        o_sv_next  = o_sv_reg;
        o_lv_next  = o_lv_reg;
        mul_a      = sel_sum[MA_W-1:0];
        mul_b      = ics_reg;
        fin        = 1'b0;
        fin_depth  = '0;
        fin_valid  = 1'b0;
        hcmd.wr_en   = 1'b0;
        hcmd.shift   = 1'b0;
        hcmd.wr_def  = item.new_defined;
        hcmd.wr_mass = item.new_mass;
        hcmd.rd_en   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (act_t'(item.action))
                        ACT_OVERWRITE:
                        begin
                            hcmd.wr_en = 1'b1;
                        end
                        ACT_SHIFT:
                        begin
                            hcmd.wr_en = 1'b1;
                            hcmd.shift = 1'b1;
                        end
                        default:
                        begin
                            hcmd.wr_en = 1'b0;
                        end
                    endcase
                    idx_next   = '0;
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // Issue one read per cycle, fold in the previous read
                if (idx_reg != CNT_W'(LONG_WINDOW))
                begin
                    hcmd.rd_en = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    pend_next  = 1'b1;
                    pidx_next  = idx_reg[AW-1:0];
                end
                if (pend_reg)
                begin
                    sum_next = acc_sum;
                    cnt_next = acc_cnt;
                    if (pidx_reg == AW'(SW_EFF - 1))
                    begin
                        ssum_next = acc_sum;
                        scnt_next = acc_cnt;
                    end
                    if (pidx_reg == AW'(LONG_WINDOW - 1))
                    begin
                        win_next   = 1'b0;
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                // Threshold test, and sum times inv_cos_slope
                prod_next = mul_res;
                wv_next   = w_valid;
                if (w_valid && w_pos)
                begin
                    state_next = ST_MUL_LO;
                end
                else
                begin
                    fin       = 1'b1;
                    fin_valid = w_valid;
                end
            end
            ST_MUL_LO:
            begin
                mul_a      = MA_W'(prod_reg[SPLIT_W-1:0]);
                mul_b      = MUL_B_W'(DEPTH_NUM);
                num_next   = NUM_W'(mul_res) + NUM_W'(DEPTH_HALF);
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                mul_a      = MA_W'(prod_reg[PR_W-1:SPLIT_W]);
                mul_b      = MUL_B_W'(DEPTH_NUM);
                num_next   = num_reg + (NUM_W'(mul_res) << SPLIT_W);
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // Saturate at the cap, else start the reciprocal multiply
                mul_a    = MA_W'(num_reg[DEN_SHIFT+NQ_W-1:DEN_SHIFT]);
                mul_b    = RCP_LO;
                rem_next = NUM_W'(mul_res);
                if (num_reg >= sel_lim)
                begin
                    fin       = 1'b1;
                    fin_depth = sel_cap;
                    fin_valid = wv_reg;
                end
                else
                begin
                    state_next = ST_RCP;
                end
            end
            ST_RCP:
            begin
                // Add the high partial product and take the quotient bits
                mul_a     = MA_W'(num_reg[DEN_SHIFT+NQ_W-1:DEN_SHIFT]);
                mul_b     = RCP_HI;
                fin       = 1'b1;
                fin_depth = rcp_acc[RCP_SH+QW-1:RCP_SH];
                fin_valid = wv_reg;
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!o_vld_reg || result.ready)
                begin
                    o_vld_next = 1'b1;
                    o_ds_next  = DS_W'(ds_reg);
                    o_sv_next  = sv_reg;
                    o_dl_next  = DL_W'(dl_reg);
                    o_lv_next  = lv_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Close a window: short goes on to long, long goes to output
        if (fin)
        begin
            if (!win_reg)
            begin
                ds_next    = fin_depth;
                sv_next    = fin_valid;
                win_next   = 1'b1;
                state_next = ST_EVAL;
            end
            else
            begin
                dl_next    = fin_depth;
                lv_next    = fin_valid;
                state_next = ST_DONE;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            win_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            o_vld_reg <= 1'b0;
            ics_reg   <= ICS_W'(ICS_RESET);
            mcs_reg   <= MCS_W'(MCS_RESET);
            mcl_reg   <= MCL_W'(MCL_RESET);
        end
        else
        begin
            state_reg <= state_next;
            win_reg   <= win_next;
            pend_reg  <= pend_next;
            o_vld_reg <= o_vld_next;
            ics_reg   <= ics_next;
            mcs_reg   <= mcs_next;
            mcl_reg   <= mcl_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        pidx_reg <= pidx_next;
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
        ssum_reg <= ssum_next;
        scnt_reg <= scnt_next;
        prod_reg <= prod_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        wv_reg   <= wv_next;
        ds_reg   <= ds_next;
        dl_reg   <= dl_next;
        sv_reg   <= sv_next;
        lv_reg   <= lv_next;
        o_ds_reg <= o_ds_next;
        o_dl_reg <= o_dl_next;
        o_sv_reg <= o_sv_next;
        o_lv_reg <= o_lv_next;
    end

    assign result.valid       = o_vld_reg;
    assign result.depth_short = o_ds_reg;
    assign result.short_valid = o_sv_reg;
    assign result.depth_long  = o_dl_reg;
    assign result.long_valid  = o_lv_reg;

    // A new result is only loaded from the final sequencer state
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(o_vld_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the final state");

    // An invalid window reports zero depth
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (o_vld_reg && !o_sv_reg) |-> (o_ds_reg == '0))
        else $error("short depth non-zero on invalid window");

    a_long_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (o_vld_reg && !o_lv_reg) |-> (o_dl_reg == '0))
        else $error("long depth non-zero on invalid window");

    // The walk never runs past the history
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (idx_reg <= CNT_W'(LONG_WINDOW)))
        else $error("history walk index out of range");

endmodule

>>> src/wddi_hist.sv
// Mass history store: circular memory with a head pointer and per-entry
// defined flags cleared by reset. Depends on wddi_pkg.
module wddi_hist
    import wddi_pkg::*;
#(
    parameter int LONG_WINDOW = LONG_WINDOW_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  hist_cmd_t                      cmd,
    input  logic [$clog2(LONG_WINDOW)-1:0] rd_idx,
    output logic [MASS_W-1:0]              rd_mass,
    output logic                           rd_def
);

    localparam int AW = $clog2(LONG_WINDOW);

    logic [AW-1:0]          head_reg, head_next;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic [AW:0]            rd_sum;
    logic [LONG_WINDOW-1:0] def_reg, def_next;
    logic [MASS_W-1:0]      mass_mem [LONG_WINDOW];
    logic [MASS_W-1:0]      rd_mass_reg;
    logic                   rd_def_reg;

    // Work out write slot, head movement and logical-to-physical read address
    always_comb
    begin
        if (cmd.shift)
        begin
            wr_addr = (head_reg == '0) ? AW'(LONG_WINDOW - 1) : head_reg - 1'b1;
        end
        else
        begin
            wr_addr = head_reg;
        end
        head_next = (cmd.wr_en && cmd.shift) ? wr_addr : head_reg;
        def_next  = def_reg;
        if (cmd.wr_en)
        begin
            def_next[wr_addr] = cmd.wr_def;
        end
        rd_sum = {1'b0, head_reg} + {1'b0, rd_idx};
        if (rd_sum >= (AW+1)'(LONG_WINDOW))
        begin
            rd_addr = AW'(rd_sum - (AW+1)'(LONG_WINDOW));
        end
        else
        begin
            rd_addr = AW'(rd_sum);
        end
    end

    // Head pointer and defined flags; reset marks every entry undefined
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            def_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            def_reg  <= def_next;
        end
    end

    // Mass memory with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mass_mem[wr_addr] <= cmd.wr_mass;
        end
        if (cmd.rd_en)
        begin
            rd_mass_reg <= mass_mem[rd_addr];
            rd_def_reg  <= def_reg[rd_addr];
        end
    end

    assign rd_mass = rd_mass_reg;
    assign rd_def  = rd_def_reg;

endmodule

>>> test/tb_top.sv
// Testbench for windowed_drift_depth_index: a predictor of the 48-entry mass history
// checks every result transaction field by field, under randomised flow control.
// Depends on wddi_pkg, wddi_if and the windowed_drift_depth_index top level.
`timescale 1ns / 100ps

module tb_top
    import wddi_pkg::*;
;

    localparam int SHORT_LEN        = SHORT_WINDOW_DEF;
    localparam int LONG_LEN         = LONG_WINDOW_DEF;
    localparam int PHASE_ITEMS      = 64;
    localparam int NUM_PHASES       = 6;
    localparam int LONG_HOLD_AT     = 120;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT      = 3000;
    localparam int TAIL_CYCLES      = 100;

    // Action code with no operation of its own
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic signed [MASS_W-1:0] MASS_MAX = {1'b0, {(MASS_W-1){1'b1}}};
    localparam logic signed [MASS_W-1:0] MASS_MIN = {1'b1, {(MASS_W-1){1'b0}}};

    typedef struct packed {
        logic [DS_W-1:0] depth_short;
        logic            short_valid;
        logic [DL_W-1:0] depth_long;
        logic            long_valid;
    } depth_rec_t;

    // Predicts the depth pair for each accepted item and checks the results in order
    class depth_predictor;
        logic signed [MASS_W-1:0] mass_hist [LONG_LEN];
        bit                       def_hist  [LONG_LEN];
        logic [ICS_W-1:0]         inv_cos;
        logic [MCS_W-1:0]         min_short;
        logic [MCL_W-1:0]         min_long;
        depth_rec_t               expected_depths [$];
        int                       errors;

        function new();
            foreach (mass_hist[i])
            begin
                mass_hist[i] = '0;
                def_hist[i]  = 1'b0;
            end
            inv_cos   = ICS_W'(ICS_RESET);
            min_short = MCS_W'(MCS_RESET);
            min_long  = MCL_W'(MCL_RESET);
            errors    = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_INV_COS:   inv_cos   = value[ICS_W-1:0];
                REG_MIN_SHORT: min_short = value[MCS_W-1:0];
                REG_MIN_LONG:  min_long  = value[MCL_W-1:0];
                default: ;
            endcase
        endfunction

        // Sum the defined entries of the newest len entries and scale to a depth
        function void window_depth(int len, int thresh, output longint depth, output bit ok);
            longint sum;
            longint cap;
            int     count;
            sum   = 0;
            count = 0;
            if (len > LONG_LEN)
                len = LONG_LEN;
            for (int i = 0; i < len; i++)
            begin
                if (def_hist[i])
                begin
                    sum += mass_hist[i];
                    count++;
                end
            end
            ok    = (count > thresh);
            depth = 0;
            if (ok && sum > 0)
            begin
                depth = (sum * DEPTH_NUM * longint'(inv_cos) + DEPTH_HALF) / DEPTH_DEN;
                cap   = longint'(len) * CAP_PER_ENTRY;
                if (depth > cap)
                    depth = cap;
            end
        endfunction

        function void take_item(logic [ACT_W-1:0] act, logic signed [MASS_W-1:0] mass,
                                logic def);
            depth_rec_t want;
            longint     d;
            bit         ok;
            // Age the history by one entry
            if (act == ACT_SHIFT)
            begin
                for (int i = LONG_LEN - 1; i > 0; i--)
                begin
                    mass_hist[i] = mass_hist[i-1];
                    def_hist[i]  = def_hist[i-1];
                end
            end
            if (act == ACT_SHIFT || act == ACT_OVERWRITE)
            begin
                mass_hist[0] = def ? mass : '0;
                def_hist[0]  = def;
            end
            window_depth(SHORT_LEN, int'(min_short), d, ok);
            want.depth_short = d[DS_W-1:0];
            want.short_valid = ok;
            window_depth(LONG_LEN, int'(min_long), d, ok);
            want.depth_long = d[DL_W-1:0];
            want.long_valid = ok;
            expected_depths.push_back(want);
        endfunction

        function void check_depths(depth_rec_t got);
            depth_rec_t want;
            if (expected_depths.size() == 0)
            begin
                $error("result transaction with no item outstanding");
                errors++;
                return;
            end
            want = expected_depths.pop_front();
            if (got.depth_short !== want.depth_short)
            begin
                $error("depth_short: expected %0d, actual %0d", want.depth_short, got.depth_short);
                errors++;
            end
            if (got.short_valid !== want.short_valid)
            begin
                $error("short_valid: expected %0d, actual %0d", want.short_valid, got.short_valid);
                errors++;
            end
            if (got.depth_long !== want.depth_long)
            begin
                $error("depth_long: expected %0d, actual %0d", want.depth_long, got.depth_long);
                errors++;
            end
            if (got.long_valid !== want.long_valid)
            begin
                $error("long_valid: expected %0d, actual %0d", want.long_valid, got.long_valid);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 idle_cycles;
    int                 items_sent;

    depth_predictor sb = new();

    wddi_in_if  item_if();
    wddi_out_if result_if();

    windowed_drift_depth_index u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Note accepted transactions on both channels and count cycles without any
    always @(posedge clk)
    begin
        depth_rec_t got;
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if (item_if.valid && item_if.ready)
                sb.take_item(item_if.action, item_if.new_mass, item_if.new_defined);
            if (result_if.valid && result_if.ready)
            begin
                got.depth_short = result_if.depth_short;
                got.short_valid = result_if.short_valid;
                got.depth_long  = result_if.depth_long;
                got.long_valid  = result_if.long_valid;
                sb.check_depths(got);
            end
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Drop the run if nothing moves for too long
    initial
    begin : watchdog
        wait (rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("[windowed_drift_depth_index] ERROR");
        $finish;
    end

    // Result side: random stalls, busy stretches and one long hold-off
    initial
    begin : result_sink
        int gap;
        int taken;
        taken = 0;
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken == LONG_HOLD_AT)
                gap = LONG_HOLD_CYCLES;
            else if ((taken % 64) < 20)
                gap = 0;
            else
                gap = $urandom_range(0, 7);
            if (gap > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!result_if.valid);
            taken++;
        end
    end

    task automatic apb_write(reg_idx_t idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic [ICS_W-1:0] ics, logic [MCS_W-1:0] mcs,
                              logic [MCL_W-1:0] mcl);
        apb_write(REG_INV_COS, PDATA_W'(ics));
        apb_write(REG_MIN_SHORT, PDATA_W'(mcs));
        apb_write(REG_MIN_LONG, PDATA_W'(mcl));
    endtask

    // Offer one item after a random gap and hold it until taken
    task automatic offer_item(logic [ACT_W-1:0] act, logic signed [MASS_W-1:0] mass, logic def);
        int gap;
        gap = ((items_sent % 64) < 16) ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid       <= 1'b1;
        item_if.action      <= act;
        item_if.new_mass    <= mass;
        item_if.new_defined <= def;
        do @(posedge clk); while (!item_if.ready);
        items_sent++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        item_if.valid <= 1'b0;
        do @(posedge clk); while (sb.expected_depths.size() != 0);
    endtask

    // Mostly shifted-in defined masses; sizes weighted towards the uncapped range
    task automatic offer_random_item();
        logic [ACT_W-1:0]         act;
        logic signed [MASS_W-1:0] mass;
        int                       w;
        int                       m;
        w = $urandom_range(0, 99);
        if (w < 60)
            act = ACT_SHIFT;
        else if (w < 75)
            act = ACT_OVERWRITE;
        else if (w < 90)
            act = ACT_RECOMPUTE;
        else
            act = ACT_UNUSED;
        w = $urandom_range(0, 99);
        if (w < 45)
            m = int'($urandom_range(0, 112)) - 48;
        else if (w < 65)
            m = int'($urandom_range(0, 4000)) - 2000;
        else if (w < 85)
            m = int'($urandom_range(0, 65535));
        else
            m = int'($urandom());
        mass = MASS_W'(m);
        offer_item(act, mass, $urandom_range(0, 99) < 85);
    endtask

    initial
    begin : stimulus
        items_sent          = 0;
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        item_if.valid       <= 1'b0;
        item_if.action      <= ACT_RECOMPUTE;
        item_if.new_mass    <= '0;
        item_if.new_defined <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset register values
        offer_item(ACT_RECOMPUTE, MASS_W'(0), 1'b1);
        offer_item(ACT_UNUSED, MASS_MAX, 1'b1);
        offer_item(ACT_SHIFT, MASS_MAX, 1'b1);
        offer_item(ACT_OVERWRITE, MASS_MIN, 1'b1);
        offer_item(ACT_OVERWRITE, MASS_MAX, 1'b0);
        // Fill the short window past its threshold, through the at-threshold count
        repeat (11) offer_item(ACT_SHIFT, MASS_W'(15), 1'b1);
        // Negative sum, then the largest mass brings the sum back positive
        offer_item(ACT_SHIFT, MASS_MIN, 1'b1);
        offer_item(ACT_SHIFT, MASS_MAX, 1'b1);
        offer_item(ACT_SHIFT, MASS_W'(0), 1'b0);
        offer_item(ACT_OVERWRITE, MASS_W'(-1), 1'b1);
        offer_item(ACT_RECOMPUTE, MASS_W'(5), 1'b0);
        offer_item(ACT_UNUSED, MASS_MIN, 1'b0);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0: set_config(16'hFFFF, 4'd0, 6'd0);
                1: set_config(16'd16384, 4'd12, 6'd48);
                2: set_config(ICS_W'($urandom_range(0, 65535)), 4'd15, 6'd63);
                3: set_config(ICS_W'($urandom_range(16384, 65535)),
                              MCS_W'($urandom_range(0, 12)), MCL_W'($urandom_range(0, 48)));
                4: set_config(16'd1, 4'd5, 6'd20);
                default: set_config(ICS_W'(ICS_RESET), MCS_W'(MCS_RESET), MCL_W'(MCL_RESET));
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // Let the block run dry once in the middle of a phase
                if (ph == 3 && k == PHASE_ITEMS / 2)
                    wait_drained();
                offer_random_item();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_depths.size() == 0)
            $display("[windowed_drift_depth_index] OK");
        else
            $display("[windowed_drift_depth_index] ERROR");
        $finish;
    end

endmodule
